FILE: hw/rtl/icf_pkg.sv
`default_nettype none

package icf_pkg;

   // cordic
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int ITER_W       = $clog2(CORDIC_ITERS + 1);
   localparam int ATAN_IDX_W   = 5;
   localparam int VEC_W        = 28;
   localparam int ANG_W        = 26;
   localparam int OUT_ANG_W    = 25;
   localparam int OPERAND_SHIFT = 8;

   localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
   localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 17;
   localparam int TIME_W   = 20;
   localparam int SUM_W    = 32;
   localparam int SAT_IN_W = 36;

   // rate lane: |rate| * t * 64, then rounded division by 15625
   localparam int NUM_LANES   = 6;
   localparam int PROD_W      = RATE_W + TIME_W;
   localparam int PRESHIFT    = 6;
   localparam int DIVIDEND_W  = PROD_W + PRESHIFT;
   localparam int QUOT_W      = 29;
   localparam int REM_W       = DIVIDEND_W - QUOT_W;
   localparam int DELTA_W     = QUOT_W + 1;
   localparam int DIV_CONST   = 15625;
   localparam int ROUND_CONST = 7812;
   localparam int MUL_STEPS   = TIME_W;
   localparam int DIV_STEPS   = QUOT_W;
   localparam int CNT_W       = $clog2(DIV_STEPS + 1);

   // square root
   localparam int SQ_W        = 32;
   localparam int SQRT_IN_W   = 48;
   localparam int ROOT_W      = SQRT_IN_W / 2;
   localparam int SQRT_REM_W  = ROOT_W + 2;

   // blend
   localparam int WEIGHT_W  = 17;
   localparam int BLEND_W   = 52;
   localparam int FRAC_W    = 16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd64225;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIFT_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIFT_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIFT_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BLEND_WEIGHT = 3'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SQRT,
      ST_WAIT_MAG,
      ST_WAIT_ALL,
      ST_WAIT_BLEND
   } state_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      if (v[SAT_IN_W-1:SUM_W-1] == {(SAT_IN_W-SUM_W+1){v[SAT_IN_W-1]}}) begin
         r = v[SUM_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         r = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(SUM_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/icf_cordic.sv
`default_nettype none

module icf_cordic import icf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [VEC_W-1:0]     vec_y,
   input  logic signed [VEC_W-1:0]     vec_x,
   output logic                        valid,
   output logic signed [OUT_ANG_W-1:0] angle
);

   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in, shx, shy;
   logic signed [ANG_W-1:0] z_ff, z_in, step_ang;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic                    busy_ff, busy_in, valid_ff, valid_in, zero_ff, zero_in;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      iter_in  = iter_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      zero_in  = zero_ff;
      shx      = x_ff >>> iter_ff;
      shy      = y_ff >>> iter_ff;
      step_ang = atan_entry(ATAN_IDX_W'(iter_ff));
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         iter_in  = '0;
         zero_in  = (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            // left half plane: quarter turn first
            if (vec_y >= 0) begin
               x_in = vec_y;
               y_in = -vec_x;
               z_in = DEG90;
            end else begin
               x_in = -vec_y;
               y_in = vec_x;
               z_in = -DEG90;
            end
         end else begin
            x_in = vec_x;
            y_in = vec_y;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + shy;
            y_in = y_ff - shx;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - shy;
            y_in = y_ff + shx;
            z_in = z_ff - step_ang;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_ITERS - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         angle = '0;
      end else if (z_ff > DEG180) begin
         angle = OUT_ANG_W'(DEG180);
      end else if (z_ff < -DEG180) begin
         angle = OUT_ANG_W'(-DEG180);
      end else begin
         angle = z_ff[OUT_ANG_W-1:0];
      end
   end

   assign valid = valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/icf_sqrt.sv
`default_nettype none

module icf_sqrt import icf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQRT_IN_W-1:0] radicand,
   output logic                 valid,
   output logic [ROOT_W-1:0]    root
);

   logic [SQRT_IN_W-1:0]  vsh_ff, vsh_in;
   logic [SQRT_REM_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, valid_ff, valid_in;
   logic [SQRT_REM_W+1:0] cand, trial;

   // restoring square root, two radicand bits per step
   always_comb begin
      vsh_in   = vsh_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      cand     = {rem_ff, vsh_ff[SQRT_IN_W-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      if (start) begin
         vsh_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         if (cand >= trial) begin
            rem_in  = SQRT_REM_W'(cand - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cand[SQRT_REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         vsh_in = {vsh_ff[SQRT_IN_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      vsh_ff  <= vsh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign valid = valid_ff;
   assign root  = root_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/icf_rate.sv
`default_nettype none

module icf_rate import icf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [RATE_W-1:0]  rate,
   input  logic [TIME_W-1:0]         interval,
   output logic                      valid,
   output logic signed [DELTA_W-1:0] delta
);

   logic                  busy_ff, busy_in, div_ff, div_in, valid_ff, valid_in, neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in, mcand_ff, mcand_in;
   logic [TIME_W-1:0]     tsh_ff, tsh_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [QUOT_W-1:0]     qsh_ff, qsh_in;
   logic [DIVIDEND_W-1:0] dividend;
   logic [REM_W:0]        trial;
   logic [RATE_W-1:0]     mag;
   logic [DELTA_W-1:0]    quot;

   // shift-add multiply over the interval bits, then long division by the
   // constant one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      div_in   = div_ff;
      valid_in = valid_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      tsh_in   = tsh_ff;
      rem_in   = rem_ff;
      qsh_in   = qsh_ff;
      mag      = rate[RATE_W-1] ? RATE_W'(-rate) : RATE_W'(rate);
      dividend = {prod_ff, {PRESHIFT{1'b0}}} + DIVIDEND_W'(ROUND_CONST);
      trial    = {rem_ff, qsh_ff[QUOT_W-1]};
      if (start) begin
         busy_in  = 1'b1;
         div_in   = 1'b0;
         valid_in = 1'b0;
         neg_in   = rate[RATE_W-1];
         cnt_in   = '0;
         prod_in  = '0;
         mcand_in = PROD_W'(mag);
         tsh_in   = interval;
      end else if (busy_ff && !div_ff) begin
         if (tsh_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[PROD_W-2:0], 1'b0};
         tsh_in   = {1'b0, tsh_ff[TIME_W-1:1]};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
            div_in = 1'b1;
            cnt_in = '0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '0) begin
            rem_in = dividend[DIVIDEND_W-1 -: REM_W];
            qsh_in = dividend[QUOT_W-1:0];
         end else begin
            if (trial >= (REM_W+1)'(DIV_CONST)) begin
               rem_in = REM_W'(trial - (REM_W+1)'(DIV_CONST));
               qsh_in = {qsh_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[REM_W-1:0];
               qsh_in = {qsh_ff[QUOT_W-2:0], 1'b0};
            end
            if (cnt_ff == CNT_W'(DIV_STEPS)) begin
               busy_in  = 1'b0;
               valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         div_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         div_ff   <= div_in;
         valid_ff <= valid_in;
      end
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      tsh_ff   <= tsh_in;
      rem_ff   <= rem_in;
      qsh_ff   <= qsh_in;
   end

   assign quot  = {1'b0, qsh_ff};
   assign delta = neg_ff ? -signed'(quot) : signed'(quot);
   assign valid = valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/icf_blend.sv
`default_nettype none

module icf_blend import icf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [WEIGHT_W-1:0]         weight,
   input  logic signed [SUM_W-1:0]     base,
   input  logic signed [OUT_ANG_W-1:0] accel,
   output logic                        valid,
   output logic signed [SUM_W-1:0]     result
);

   logic signed [BLEND_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [WEIGHT_W-1:0]       wsh_ff, wsh_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, valid_ff, valid_in;

   // w*b + (1-w)*a + half  ==  w*(b-a) + a*2^16 + half, one weight bit per cycle
   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      wsh_in   = wsh_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (start) begin
         acc_in   = {{(BLEND_W-OUT_ANG_W-FRAC_W){accel[OUT_ANG_W-1]}}, accel,
                     1'b1, {(FRAC_W-1){1'b0}}};
         mcand_in = BLEND_W'(base) - BLEND_W'(accel);
         wsh_in   = weight;
         cnt_in   = '0;
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         if (wsh_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         wsh_in   = {1'b0, wsh_ff[WEIGHT_W-1:1]};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WEIGHT_W - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      wsh_ff   <= wsh_in;
      cnt_ff   <= cnt_in;
   end

   assign result = sat32(acc_ff[BLEND_W-1 -: SAT_IN_W]);
   assign valid  = valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/imu_complementary_filter_unit.sv
// channel  | direction | handshake            | beat contents
// req      | in        | req_valid/req_stall  | accel x/y/z, gyro x/y/z, interval_us
// rsp      | out       | rsp_valid/rsp_stall  | accel roll/pitch, raw, fixed, fused angles
// csr      | in        | csr_valid/csr_ready  | register index and write data
//
// the time from a req beat to its rsp beat is set by the gyro rate lanes
// (20 shift-add multiply steps, one load and 29 divide steps) followed by the 17-step blend
// one sample is worked on at a time; req_stall is high from accept until the
// result is loaded into the rsp register, which may still be waiting on rsp_stall
// with rsp free the next req beat is taken only after the previous result is loaded
// synchronous active-high reset clears angle state and drifts and sets the blend weight to its reset value

`default_nettype none

module imu_complementary_filter_unit import icf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // sample in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_W-1:0]    req_accel_x,
   input  logic signed [SAMPLE_W-1:0]    req_accel_y,
   input  logic signed [SAMPLE_W-1:0]    req_accel_z,
   input  logic signed [SAMPLE_W-1:0]    req_gyro_x,
   input  logic signed [SAMPLE_W-1:0]    req_gyro_y,
   input  logic signed [SAMPLE_W-1:0]    req_gyro_z,
   input  logic [TIME_W-1:0]             req_interval_us,
   // angles out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_ANG_W-1:0]   rsp_acc_roll,
   output logic signed [OUT_ANG_W-1:0]   rsp_acc_pitch,
   output logic signed [SUM_W-1:0]       rsp_raw_roll_out,
   output logic signed [SUM_W-1:0]       rsp_raw_pitch_out,
   output logic signed [SUM_W-1:0]       rsp_raw_yaw_out,
   output logic signed [SUM_W-1:0]       rsp_fixed_roll_out,
   output logic signed [SUM_W-1:0]       rsp_fixed_pitch_out,
   output logic signed [SUM_W-1:0]       rsp_fixed_yaw_out,
   output logic signed [SUM_W-1:0]       rsp_fused_roll_out,
   output logic signed [SUM_W-1:0]       rsp_fused_pitch_out,
   output logic signed [SUM_W-1:0]       rsp_fused_yaw_out,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   state_type state_ff, state_in;

   // control strobes
   logic load_item, units_start, sqrt_start, pitch_start, sums_update, rsp_load;

   // captured sample
   logic signed [SAMPLE_W-1:0] ax_ff, ay_ff, az_ff, gx_ff, gy_ff, gz_ff;
   logic [TIME_W-1:0]          t_ff;

   // configuration
   logic signed [SAMPLE_W-1:0] drift_x_ff, drift_y_ff, drift_z_ff;
   logic [WEIGHT_W-1:0]        weight_ff, weight_eff;

   // angle state
   logic signed [SUM_W-1:0] raw_roll_ff, raw_pitch_ff, raw_yaw_ff;
   logic signed [SUM_W-1:0] fix_roll_ff, fix_pitch_ff, fix_yaw_ff;
   logic signed [SUM_W-1:0] bl_roll_ff, bl_pitch_ff, bl_yaw_ff;
   logic signed [SUM_W-1:0] bl_roll_base, bl_pitch_base;

   // accelerometer path
   logic signed [SQ_W-1:0]     ay_sq, az_sq;
   logic [SQ_W-1:0]            sq_ff, sq_sum;
   logic [SQRT_IN_W-1:0]       radicand;
   logic [ROOT_W-1:0]          mag;
   logic                       sqrt_valid, roll_valid, pitch_valid;
   logic signed [VEC_W-1:0]    roll_y, roll_x, pitch_y, pitch_x;
   logic signed [OUT_ANG_W-1:0] roll_ang, pitch_ang;

   // gyro lanes: raw x/y/z then drift-corrected x/y/z
   logic signed [RATE_W-1:0]  lane_rate  [NUM_LANES];
   logic signed [DELTA_W-1:0] lane_delta [NUM_LANES];
   logic [NUM_LANES-1:0]      lane_valid;

   logic                    blr_valid, blp_valid;
   logic signed [SUM_W-1:0] blr_result, blp_result;

   // rsp register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_ANG_W-1:0] rsp_acc_roll_ff, rsp_acc_pitch_ff;
   logic signed [SUM_W-1:0]     rsp_raw_roll_ff, rsp_raw_pitch_ff, rsp_raw_yaw_ff;
   logic signed [SUM_W-1:0]     rsp_fix_roll_ff, rsp_fix_pitch_ff, rsp_fix_yaw_ff;
   logic signed [SUM_W-1:0]     rsp_bl_roll_ff, rsp_bl_pitch_ff, rsp_bl_yaw_ff;

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      load_item   = 1'b0;
      units_start = 1'b0;
      sqrt_start  = 1'b0;
      pitch_start = 1'b0;
      sums_update = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               load_item = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // gyro lanes and roll cordic start, first square taken
            units_start = 1'b1;
            state_in    = ST_SQRT;
         end
         ST_SQRT: begin
            sqrt_start = 1'b1;
            state_in   = ST_WAIT_MAG;
         end
         ST_WAIT_MAG: begin
            if (sqrt_valid) begin
               pitch_start = 1'b1;
               state_in    = ST_WAIT_ALL;
            end
         end
         ST_WAIT_ALL: begin
            // integrate all sets, kick off the roll and pitch blends
            if ((&lane_valid) && roll_valid && pitch_valid) begin
               sums_update = 1'b1;
               state_in    = ST_WAIT_BLEND;
            end
         end
         ST_WAIT_BLEND: begin
            if (blr_valid && blp_valid && (!rsp_valid_ff || !rsp_stall)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drift_x_ff <= '0;
         drift_y_ff <= '0;
         drift_z_ff <= '0;
         weight_ff  <= WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DRIFT_X:      drift_x_ff <= signed'(csr_wdata[SAMPLE_W-1:0]);
            REG_DRIFT_Y:      drift_y_ff <= signed'(csr_wdata[SAMPLE_W-1:0]);
            REG_DRIFT_Z:      drift_z_ff <= signed'(csr_wdata[SAMPLE_W-1:0]);
            REG_BLEND_WEIGHT: weight_ff  <= csr_wdata[WEIGHT_W-1:0];
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // weights above one behave as one
   assign weight_eff = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;

   // ---------------------------------------------------------------- sample capture
   always_ff @(posedge clock) begin
      if (load_item) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         gx_ff <= req_gyro_x;
         gy_ff <= req_gyro_y;
         gz_ff <= req_gyro_z;
         t_ff  <= req_interval_us;
      end
      if (units_start) begin
         sq_ff <= ay_sq;
      end
   end

   // ---------------------------------------------------------------- accelerometer angles
   assign ay_sq    = ay_ff * ay_ff;
   assign az_sq    = az_ff * az_ff;
   assign sq_sum   = sq_ff + SQ_W'(az_sq);
   // (ay^2 + az^2) * 2^16 so the root lands on the 256x operand scale
   assign radicand = {sq_sum, {(SQRT_IN_W-SQ_W){1'b0}}};

   assign roll_y  = VEC_W'(signed'({ay_ff, {OPERAND_SHIFT{1'b0}}}));
   assign roll_x  = VEC_W'(signed'({az_ff, {OPERAND_SHIFT{1'b0}}}));
   assign pitch_y = -VEC_W'(signed'({ax_ff, {OPERAND_SHIFT{1'b0}}}));
   assign pitch_x = VEC_W'(signed'({1'b0, mag}));

   icf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .valid    (sqrt_valid),
      .root     (mag)
   );

   icf_cordic u_cordic_roll (
      .clock (clock),
      .reset (reset),
      .start (units_start),
      .vec_y (roll_y),
      .vec_x (roll_x),
      .valid (roll_valid),
      .angle (roll_ang)
   );

   icf_cordic u_cordic_pitch (
      .clock (clock),
      .reset (reset),
      .start (pitch_start),
      .vec_y (pitch_y),
      .vec_x (pitch_x),
      .valid (pitch_valid),
      .angle (pitch_ang)
   );

   // ---------------------------------------------------------------- gyro lanes
   always_comb begin
      lane_rate[0] = RATE_W'(gx_ff);
      lane_rate[1] = RATE_W'(gy_ff);
      lane_rate[2] = RATE_W'(gz_ff);
      lane_rate[3] = RATE_W'(gx_ff) - RATE_W'(drift_x_ff);
      lane_rate[4] = RATE_W'(gy_ff) - RATE_W'(drift_y_ff);
      lane_rate[5] = RATE_W'(gz_ff) - RATE_W'(drift_z_ff);
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      icf_rate u_rate (
         .clock    (clock),
         .reset    (reset),
         .start    (units_start),
         .rate     (lane_rate[g]),
         .interval (t_ff),
         .valid    (lane_valid[g]),
         .delta    (lane_delta[g])
      );
   end

   // ---------------------------------------------------------------- integration
   assign bl_roll_base  = sat32(SAT_IN_W'(bl_roll_ff) + SAT_IN_W'(lane_delta[3]));
   assign bl_pitch_base = sat32(SAT_IN_W'(bl_pitch_ff) + SAT_IN_W'(lane_delta[4]));

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_roll_ff  <= '0;
         raw_pitch_ff <= '0;
         raw_yaw_ff   <= '0;
         fix_roll_ff  <= '0;
         fix_pitch_ff <= '0;
         fix_yaw_ff   <= '0;
         bl_roll_ff   <= '0;
         bl_pitch_ff  <= '0;
         bl_yaw_ff    <= '0;
      end else begin
         if (sums_update) begin
            raw_roll_ff  <= sat32(SAT_IN_W'(raw_roll_ff) + SAT_IN_W'(lane_delta[0]));
            raw_pitch_ff <= sat32(SAT_IN_W'(raw_pitch_ff) + SAT_IN_W'(lane_delta[1]));
            raw_yaw_ff   <= sat32(SAT_IN_W'(raw_yaw_ff) + SAT_IN_W'(lane_delta[2]));
            fix_roll_ff  <= sat32(SAT_IN_W'(fix_roll_ff) + SAT_IN_W'(lane_delta[3]));
            fix_pitch_ff <= sat32(SAT_IN_W'(fix_pitch_ff) + SAT_IN_W'(lane_delta[4]));
            fix_yaw_ff   <= sat32(SAT_IN_W'(fix_yaw_ff) + SAT_IN_W'(lane_delta[5]));
            // fused yaw has no accelerometer reference
            bl_yaw_ff    <= sat32(SAT_IN_W'(bl_yaw_ff) + SAT_IN_W'(lane_delta[5]));
         end
         if (rsp_load) begin
            bl_roll_ff  <= blr_result;
            bl_pitch_ff <= blp_result;
         end
      end
   end

   // ---------------------------------------------------------------- blend
   icf_blend u_blend_roll (
      .clock  (clock),
      .reset  (reset),
      .start  (sums_update),
      .weight (weight_eff),
      .base   (bl_roll_base),
      .accel  (roll_ang),
      .valid  (blr_valid),
      .result (blr_result)
   );

   icf_blend u_blend_pitch (
      .clock  (clock),
      .reset  (reset),
      .start  (sums_update),
      .weight (weight_eff),
      .base   (bl_pitch_base),
      .accel  (pitch_ang),
      .valid  (blp_valid),
      .result (blp_result)
   );

   // ---------------------------------------------------------------- rsp register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_acc_roll_ff  <= roll_ang;
         rsp_acc_pitch_ff <= pitch_ang;
         rsp_raw_roll_ff  <= raw_roll_ff;
         rsp_raw_pitch_ff <= raw_pitch_ff;
         rsp_raw_yaw_ff   <= raw_yaw_ff;
         rsp_fix_roll_ff  <= fix_roll_ff;
         rsp_fix_pitch_ff <= fix_pitch_ff;
         rsp_fix_yaw_ff   <= fix_yaw_ff;
         rsp_bl_roll_ff   <= blr_result;
         rsp_bl_pitch_ff  <= blp_result;
         rsp_bl_yaw_ff    <= bl_yaw_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_acc_roll        = rsp_acc_roll_ff;
   assign rsp_acc_pitch       = rsp_acc_pitch_ff;
   assign rsp_raw_roll_out    = rsp_raw_roll_ff;
   assign rsp_raw_pitch_out   = rsp_raw_pitch_ff;
   assign rsp_raw_yaw_out     = rsp_raw_yaw_ff;
   assign rsp_fixed_roll_out  = rsp_fix_roll_ff;
   assign rsp_fixed_pitch_out = rsp_fix_pitch_ff;
   assign rsp_fixed_yaw_out   = rsp_fix_yaw_ff;
   assign rsp_fused_roll_out  = rsp_bl_roll_ff;
   assign rsp_fused_pitch_out = rsp_bl_pitch_ff;
   assign rsp_fused_yaw_out   = rsp_bl_yaw_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/icf_checker.sv
`default_nettype none

module icf_checker import icf_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [OUT_ANG_W-1:0] rsp_acc_roll,
   input logic signed [SUM_W-1:0]     rsp_fused_yaw_out
);

   // no result beat straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a taken sample keeps the input closed on the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second sample taken while busy");

   // a fresh result only appears while a sample is in progress
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat with no sample in progress");

   // held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_acc_roll) && $stable(rsp_fused_yaw_out)))
      else $error("stalled result beat changed");

endmodule

bind imu_complementary_filter_unit icf_checker u_icf_checker (.*);

`default_nettype wire
